// ===== rtl/htlf_pkg.sv =====
// ----------------------------------------------------------------------------
// htlf_pkg
// Types and constants shared by the tile map line fetch unit.
// ----------------------------------------------------------------------------
package htlf_pkg;

    localparam int MAP_AW   = 6;
    localparam int BIG_AW   = 14;
    localparam int SMALL_AW = 12;
    localparam int WORD_AW  = SMALL_AW - 2;
    localparam int DIV_W    = 17;
    localparam int MOD_W    = 7;
    localparam int REM_W    = 6;
    localparam int BLK_W    = 11;
    localparam int RECIP_SH = DIV_W + 6;
    localparam int RECIP_W  = RECIP_SH + 1;

    localparam logic [1:0] FUNC_WR_MAP   = 2'd0;
    localparam logic [1:0] FUNC_WR_BIG   = 2'd1;
    localparam logic [1:0] FUNC_WR_SMALL = 2'd2;
    localparam logic [1:0] FUNC_FETCH    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_X,
        ST_MOD_Y,
        ST_MAP,
        ST_BIG,
        ST_SMALL
    } state_t;

endpackage

// ===== rtl/htlf_mod_unit.sv =====
// ----------------------------------------------------------------------------
// htlf_mod_unit
// Remainder by a small divisor through reciprocal multiplication: operand capture, multiply, subtract.
// ----------------------------------------------------------------------------
module htlf_mod_unit
    import htlf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_W-1:0]   dividend,
    input  logic [MOD_W-1:0]   divisor,
    input  logic [RECIP_W-1:0] recip,
    output logic               done,
    output logic [REM_W-1:0]   remainder
);

    localparam int PROD_W = DIV_W + RECIP_W;

    logic [DIV_W-1:0]   num_reg;
    logic [MOD_W-1:0]   div_reg;
    logic [RECIP_W-1:0] recip_reg;
    logic [DIV_W-1:0]   quot_reg;
    logic [REM_W-1:0]   rem_reg;
    logic               mul_reg;
    logic               sub_reg;
    logic               done_reg;
    logic [PROD_W-1:0]  prod;
    logic [DIV_W-1:0]   back;
    logic [DIV_W-1:0]   diff;

    assign prod = PROD_W'(num_reg) * PROD_W'(recip_reg);
    assign back = quot_reg * DIV_W'(div_reg);
    assign diff = num_reg - back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= start;
            sub_reg  <= mul_reg;
            done_reg <= sub_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg   <= dividend;
            div_reg   <= divisor;
            recip_reg <= recip;
        end
        if (mul_reg)
        begin
            quot_reg <= prod[RECIP_SH +: DIV_W];
        end
        if (sub_reg)
        begin
            rem_reg <= diff[REM_W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/hierarchical_tilemap_line_fetch_unit.sv =====
// ----------------------------------------------------------------------------
// hierarchical_tilemap_line_fetch_unit
// Three-level tile map with table loading and one-row cell fetch.
// ----------------------------------------------------------------------------
// A write request (func 0, 1, 2) loads one byte into the block map, the big
// block store or the small block store and leaves req_stall low. A fetch
// request (func 3) of N output words holds req_stall high after it is taken:
// two passes through the shared reciprocal remainder unit wrap the block
// column and row, then each word needs a big block read followed by a small
// block read from the single-port stores, plus one block map read per big
// block. The fetch waits in the small block read while the output register
// stays full. req_stall is high for the whole fetch; the last word sits in
// the output register while the next request is taken.
module hierarchical_tilemap_line_fetch_unit
    import htlf_pkg::*;
#(
    parameter int MAP_WIDTH_BLOCKS  = 8,
    parameter int MAP_HEIGHT_BLOCKS = 8,
    parameter int MAX_CELLS         = 96
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  func,
    input  logic [13:0] addr,
    input  logic [7:0]  data,
    input  logic signed [15:0] cell_x,
    input  logic signed [15:0] cell_y,
    input  logic [6:0]  cell_count,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [31:0] cells_word,
    output logic        last
);

    localparam logic [DIV_W-1:0] X_OFFSET = DIV_W'(1024 * MAP_WIDTH_BLOCKS);
    localparam logic [DIV_W-1:0] Y_OFFSET = DIV_W'(1024 * MAP_HEIGHT_BLOCKS);
    localparam logic [RECIP_W-1:0] X_RECIP =
        RECIP_W'(((1 << RECIP_SH) + MAP_WIDTH_BLOCKS - 1) / MAP_WIDTH_BLOCKS);
    localparam logic [RECIP_W-1:0] Y_RECIP =
        RECIP_W'(((1 << RECIP_SH) + MAP_HEIGHT_BLOCKS - 1) / MAP_HEIGHT_BLOCKS);

    logic [7:0]  block_map [0:(1 << MAP_AW)-1];
    logic [7:0]  big_store [0:(1 << BIG_AW)-1];
    logic [31:0] small_store [0:(1 << WORD_AW)-1];

    state_t state_reg, state_next;

    logic                req_take;
    logic                out_free;
    logic [8:0]          sat_count;
    logic [5:0]          nwords;
    logic                mod_start;
    logic                mod_y_pass;
    logic [DIV_W-1:0]    mod_dividend;
    logic [MOD_W-1:0]    mod_divisor;
    logic [RECIP_W-1:0]  mod_recip;
    logic                mod_done;
    logic [REM_W-1:0]    mod_rem;
    logic [BLK_W-1:0]    x_blk;
    logic                word_last;
    logic [MAP_AW-1:0]   map_addr;

    logic [BLK_W-1:0]    y_blk_reg;
    logic [4:0]          y_row_reg;
    logic [5:0]          nwords_reg;
    logic [4:0]          w_reg;
    logic [REM_W-1:0]    col_reg;
    logic [MAP_AW-1:0]   row_base_reg;
    logic [7:0]          map_data_reg;
    logic [7:0]          small_idx_reg;
    logic [31:0]         cells_word_reg;
    logic                last_reg;
    logic                word_valid_reg;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !word_valid_reg || !word_stall;

    assign sat_count = ({2'b00, cell_count} > 9'(MAX_CELLS)) ? 9'(MAX_CELLS)
                                                              : {2'b00, cell_count};
    assign nwords    = 6'((sat_count + 9'd3) >> 2);

    assign x_blk     = cell_x[15:5];
    assign word_last = ((6'(w_reg) + 6'd1) == nwords_reg);
    assign map_addr  = row_base_reg + MAP_AW'(col_reg);

    // column pass starts from idle, row pass starts from the column pass
    assign mod_y_pass   = (state_reg != ST_IDLE);
    assign mod_divisor  = mod_y_pass ? MOD_W'(MAP_HEIGHT_BLOCKS)
                                     : MOD_W'(MAP_WIDTH_BLOCKS);
    assign mod_recip    = mod_y_pass ? Y_RECIP : X_RECIP;
    assign mod_dividend = mod_y_pass
                          ? (DIV_W'(signed'(y_blk_reg)) + Y_OFFSET)
                          : (DIV_W'(signed'(x_blk)) + X_OFFSET);

    htlf_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .recip     (mod_recip),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        mod_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_take && func == FUNC_FETCH && nwords != 6'd0)
                begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD_X;
                end
            end
            ST_MOD_X:
            begin
                if (mod_done)
                begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD_Y;
                end
            end
            ST_MOD_Y:
            begin
                if (mod_done)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                state_next = ST_BIG;
            end
            ST_BIG:
            begin
                state_next = ST_SMALL;
            end
            ST_SMALL:
            begin
                if (out_free)
                begin
                    if (word_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (w_reg[2:0] == 3'd7)
                    begin
                        state_next = ST_MAP;
                    end
                    else
                    begin
                        state_next = ST_BIG;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SMALL && out_free)
            begin
                word_valid_reg <= 1'b1;
            end
            else if (!word_stall)
            begin
                word_valid_reg <= 1'b0;
            end
        end
    end

    // hold fetch context and advance along the row
    always_ff @(posedge clk)
    begin
        if (req_take && func == FUNC_FETCH)
        begin
            y_blk_reg  <= cell_y[15:5];
            y_row_reg  <= cell_y[4:0];
            nwords_reg <= nwords;
            w_reg      <= '0;
        end
        if (state_reg == ST_MOD_X && mod_done)
        begin
            col_reg <= mod_rem;
        end
        if (state_reg == ST_MOD_Y && mod_done)
        begin
            row_base_reg <= MAP_AW'(mod_rem * MAP_WIDTH_BLOCKS);
        end
        if (state_reg == ST_SMALL && out_free)
        begin
            cells_word_reg <= small_store[{small_idx_reg, y_row_reg[1:0]}];
            last_reg       <= word_last;
            w_reg          <= w_reg + 5'd1;
            if (w_reg[2:0] == 3'd7)
            begin
                col_reg <= (col_reg == REM_W'(MAP_WIDTH_BLOCKS - 1)) ? '0
                                                                     : col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take && func == FUNC_WR_MAP)
        begin
            block_map[addr[MAP_AW-1:0]] <= data;
        end
        if (state_reg == ST_MAP)
        begin
            map_data_reg <= block_map[map_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take && func == FUNC_WR_BIG)
        begin
            big_store[addr[BIG_AW-1:0]] <= data;
        end
        if (state_reg == ST_BIG)
        begin
            small_idx_reg <= big_store[{map_data_reg, y_row_reg[4:2], w_reg[2:0]}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take && func == FUNC_WR_SMALL)
        begin
            small_store[addr[SMALL_AW-1:2]][8*addr[1:0] +: 8] <= data;
        end
    end

    assign word_valid = word_valid_reg;
    assign cells_word = cells_word_reg;
    assign last       = last_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tile map line fetch unit.
// ----------------------------------------------------------------------------
// Load requests fill the block map and the big and small block stores. Fetch
// requests read back one cell row. Before each fetch, any table entry that
// the fetch would read and that has never been loaded gets a load request of
// its own; block indices come from a small pool so these loads stay few. The
// bench keeps its own copy of the three tables, updated as requests are
// accepted, and builds the expected cell words from it. Each word that
// leaves the unit is compared with the oldest expected word. Both
// handshakes idle at random, except for one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module testbench;
    import htlf_pkg::*;

    localparam int MAP_WIDTH_BLOCKS  = 8;
    localparam int MAP_HEIGHT_BLOCKS = 8;
    localparam int MAX_CELLS         = 96;
    localparam int MAP_MASK   = (1 << MAP_AW) - 1;
    localparam int BIG_MASK   = (1 << BIG_AW) - 1;
    localparam int SMALL_MASK = (1 << SMALL_AW) - 1;
    localparam int IDLE_PCT   = 33;
    localparam int NUM_ITEMS  = 150;

    typedef struct {
        logic [1:0]         fn;
        logic [13:0]        addr;
        logic [7:0]         data;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [6:0]         count;
        bit                 steady;
    } tile_req_t;

    typedef struct packed {
        logic [31:0] cells;
        logic        last;
    } line_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [1:0]         func = FUNC_WR_MAP;
    logic [13:0]        addr = '0;
    logic [7:0]         data = '0;
    logic signed [15:0] cell_x = '0;
    logic signed [15:0] cell_y = '0;
    logic [6:0]         cell_count = '0;
    logic               word_valid;
    logic               word_stall = 1'b0;
    logic [31:0]        cells_word;
    logic               last;

    tile_req_t  pending_requests[$];
    line_word_t expected_words[$];
    tile_req_t  current_req;
    bit         req_fire = 1'b0;
    bit         steady = 1'b0;
    bit         plan_steady = 1'b0;

    logic [7:0] tile_map [0:MAP_MASK];
    logic [7:0] big_blocks [0:BIG_MASK];
    logic [7:0] small_blocks [0:SMALL_MASK];

    logic [7:0] plan_map [0:MAP_MASK];
    logic [7:0] plan_big [0:BIG_MASK];
    logic [7:0] plan_small [0:SMALL_MASK];
    bit         map_known [0:MAP_MASK];
    bit         big_known [0:BIG_MASK];
    bit         small_known [0:SMALL_MASK];

    int errors = 0;
    int words_checked = 0;
    int fetches_taken = 0;
    int loads_taken = 0;

    hierarchical_tilemap_line_fetch_unit #(
        .MAP_WIDTH_BLOCKS  (MAP_WIDTH_BLOCKS),
        .MAP_HEIGHT_BLOCKS (MAP_HEIGHT_BLOCKS),
        .MAX_CELLS         (MAX_CELLS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .func       (func),
        .addr       (addr),
        .data       (data),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_count (cell_count),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .cells_word (cells_word),
        .last       (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int wrap(int v, int m);
        int r;
        r = v % m;
        if (r < 0)
            r += m;
        return r;
    endfunction

    function automatic int line_words(logic [6:0] n);
        int c;
        c = (int'(n) > MAX_CELLS) ? MAX_CELLS : int'(n);
        return (c + 3) / 4;
    endfunction

    function automatic int row_in_block(int cy);
        return wrap(cy, MAP_HEIGHT_BLOCKS * 32) % 32;
    endfunction

    function automatic int map_slot(int cx, int cy, int w);
        int col;
        int row;
        col = wrap(wrap(cx >>> 5, MAP_WIDTH_BLOCKS) + w / 8, MAP_WIDTH_BLOCKS);
        row = wrap(cy, MAP_HEIGHT_BLOCKS * 32) / 32;
        return (row * MAP_WIDTH_BLOCKS + col) & MAP_MASK;
    endfunction

    function automatic int big_slot(logic [7:0] blk, int cy, int w);
        return ((int'(blk) << 6) + ((row_in_block(cy) >> 2) << 3) + (w & 7)) & BIG_MASK;
    endfunction

    function automatic int small_slot(logic [7:0] sb, int cy);
        return ((int'(sb) << 4) + ((row_in_block(cy) & 3) << 2)) & SMALL_MASK;
    endfunction

    // two indices that toggle every bit between them
    function automatic logic [7:0] pool_index();
        return ($urandom_range(0, 1) == 0) ? 8'h5A : 8'hA5;
    endfunction

    function automatic tile_req_t blank_request(logic [1:0] fn);
        tile_req_t r;
        r.fn     = fn;
        r.addr   = 14'($urandom);
        r.data   = 8'($urandom);
        r.x      = 16'($urandom);
        r.y      = 16'($urandom);
        r.count  = 7'($urandom);
        r.steady = plan_steady;
        return r;
    endfunction

    task automatic push_load(logic [1:0] fn, int a, int d);
        tile_req_t r;
        r = blank_request(fn);
        r.addr = 14'(a);
        r.data = 8'(d);
        case (fn)
            FUNC_WR_MAP:
            begin
                plan_map[a & MAP_MASK] = r.data;
                map_known[a & MAP_MASK] = 1'b1;
            end
            FUNC_WR_BIG:
            begin
                plan_big[a & BIG_MASK] = r.data;
                big_known[a & BIG_MASK] = 1'b1;
            end
            default:
            begin
                plan_small[a & SMALL_MASK] = r.data;
                small_known[a & SMALL_MASK] = 1'b1;
            end
        endcase
        pending_requests.push_back(r);
    endtask

    // fill every table entry the fetch will read before queuing it
    task automatic push_fetch(int cx, int cy, int n);
        tile_req_t r;
        int mi;
        int bi;
        int si;
        r = blank_request(FUNC_FETCH);
        r.x = 16'(cx);
        r.y = 16'(cy);
        r.count = 7'(n);
        for (int w = 0; w < line_words(r.count); w++)
        begin
            mi = map_slot(int'(r.x), int'(r.y), w);
            if (!map_known[mi])
                push_load(FUNC_WR_MAP, ($urandom_range(0, 255) << 6) | mi,
                          int'(pool_index()));
            bi = big_slot(plan_map[mi], int'(r.y), w);
            if (!big_known[bi])
                push_load(FUNC_WR_BIG, bi, int'(pool_index()));
            for (int k = 0; k < 4; k++)
            begin
                si = (small_slot(plan_big[bi], int'(r.y)) + k) & SMALL_MASK;
                if (!small_known[si])
                    push_load(FUNC_WR_SMALL, ($urandom_range(0, 3) << 12) | si,
                              $urandom_range(0, 255));
            end
        end
        pending_requests.push_back(r);
    endtask

    task automatic predict_request(tile_req_t r);
        int mi;
        int bi;
        int si;
        int n;
        line_word_t lw;
        case (r.fn)
            FUNC_WR_MAP:
            begin
                tile_map[r.addr & MAP_MASK] = r.data;
                loads_taken++;
            end
            FUNC_WR_BIG:
            begin
                big_blocks[r.addr & BIG_MASK] = r.data;
                loads_taken++;
            end
            FUNC_WR_SMALL:
            begin
                small_blocks[r.addr & SMALL_MASK] = r.data;
                loads_taken++;
            end
            default:
            begin
                fetches_taken++;
                n = line_words(r.count);
                for (int w = 0; w < n; w++)
                begin
                    mi = map_slot(int'(r.x), int'(r.y), w);
                    bi = big_slot(tile_map[mi], int'(r.y), w);
                    si = small_slot(big_blocks[bi], int'(r.y));
                    lw.cells = '0;
                    for (int k = 3; k >= 0; k--)
                        lw.cells = {lw.cells[23:0], small_blocks[(si + k) & SMALL_MASK]};
                    lw.last = (w == n - 1);
                    expected_words.push_back(lw);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
        errors++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_fire)
            begin
                if (pending_requests.size() != 0 &&
                    (pending_requests[0].steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    current_req = pending_requests.pop_front();
                    func       <= current_req.fn;
                    addr       <= current_req.addr;
                    data       <= current_req.data;
                    cell_x     <= current_req.x;
                    cell_y     <= current_req.y;
                    cell_count <= current_req.count;
                    steady     <= current_req.steady;
                    req_valid  <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
            word_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // request monitor and predictor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_fire <= req_valid && !req_stall;
            if (req_valid && !req_stall)
                predict_request(current_req);
        end
    end

    // word checker
    always @(posedge clk)
    begin
        line_word_t want;
        if (rst_n && word_valid && !word_stall)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected word", cells_word, 32'h0);
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (cells_word !== want.cells)
                    report_mismatch("cells_word", cells_word, want.cells);
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        end
    end

    initial
    begin
        int cnt;
        int i;
        logic [1:0] fn;

        // directed: table edges, address aliasing, count and coordinate extremes
        push_load(FUNC_WR_MAP, 16383, 255);
        push_load(FUNC_WR_MAP, 0, 0);
        push_load(FUNC_WR_BIG, 16383, 0);
        push_load(FUNC_WR_BIG, 0, 255);
        push_load(FUNC_WR_SMALL, 16383, 255);
        push_load(FUNC_WR_SMALL, 4096, 0);
        push_fetch(-32768, -32768, 0);
        push_fetch(32767, 32767, 1);
        push_fetch(-1, -1, 5);
        push_fetch(31, 32, 3);
        push_fetch(224, 0, 127);
        push_fetch(-33, 1, 97);
        push_fetch(100, -256, 96);
        push_fetch(-32768, 32767, 33);

        i = 0;
        while (pending_requests.size() < NUM_ITEMS)
        begin
            plan_steady = (i >= 5 && i < 20);
            if ($urandom_range(0, 99) < 55)
            begin
                cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 96);
                push_fetch(int'($signed(16'($urandom))), int'($signed(16'($urandom))), cnt);
            end
            else
            begin
                fn = 2'($urandom_range(0, 2));
                push_load(fn, $urandom_range(0, 16383),
                          (fn == FUNC_WR_SMALL) ? int'($urandom_range(0, 255))
                                                : int'(pool_index()));
            end
            i++;
        end
        plan_steady = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || req_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (200) @(posedge clk);

        $display("tb: %0d table loads and %0d line fetches accepted, %0d cell words checked",
                 loads_taken, fetches_taken, words_checked);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
